// ===== rtl/core/smm_pkg.sv =====
// Shared types and constants for the square matrix multiply block.
// No dependencies; imported by smm_mac and square_matrix_multiply_mod64.
`default_nettype none

package smm_pkg;

    localparam int DATA_W  = 64;
    localparam int HALF_W  = 32;
    localparam int IDX_W   = 6;
    localparam int DIM_W   = 7;
    localparam int MODE_W  = 2;
    localparam int TDATA_W = 80;

    localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_C = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } smm_state_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/smm_mem.sv =====
// Element store for one matrix: one write port, one registered read port.
// No dependencies.
`default_nettype none

module smm_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int WIDTH  = 64
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/smm_mac.sv =====
// Pipelined 64x64 multiply-accumulate, low 64 bits, built from three
// 32x32 multiplies in separate stages. Depends on smm_pkg.
`default_nettype none

module smm_mac (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire smm_pkg::mac_ctl_t             ctl,
    input  wire logic [smm_pkg::DATA_W-1:0]    op_a,
    input  wire logic [smm_pkg::DATA_W-1:0]    op_b,
    output logic      [smm_pkg::DATA_W-1:0]    acc,
    output logic                               busy
);

    import smm_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic [DATA_W-1:0] ll_reg;
    logic [HALF_W-1:0] al_reg, ah_reg, bl_reg, bh_reg;
    logic [HALF_W-1:0] ah2_reg, bl2_reg;
    logic [HALF_W-1:0] lo2_reg, hi2_reg;
    logic [HALF_W-1:0] lo3_reg, hi3_reg;
    logic [DATA_W-1:0] acc_reg;

    logic [DATA_W-1:0] prod_ll, prod_x1, prod_x2;

    assign prod_ll = DATA_W'(op_a[HALF_W-1:0]) * DATA_W'(op_b[HALF_W-1:0]);
    assign prod_x1 = DATA_W'(al_reg) * DATA_W'(bh_reg);
    assign prod_x2 = DATA_W'(ah2_reg) * DATA_W'(bl2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        // stage 1: low x low
        ll_reg <= prod_ll;
        al_reg <= op_a[HALF_W-1:0];
        ah_reg <= op_a[DATA_W-1:HALF_W];
        bl_reg <= op_b[HALF_W-1:0];
        bh_reg <= op_b[DATA_W-1:HALF_W];
        // stage 2: first cross term into upper half
        lo2_reg <= ll_reg[HALF_W-1:0];
        hi2_reg <= ll_reg[DATA_W-1:HALF_W] + prod_x1[HALF_W-1:0];
        ah2_reg <= ah_reg;
        bl2_reg <= bl_reg;
        // stage 3: second cross term
        lo3_reg <= lo2_reg;
        hi3_reg <= hi2_reg + prod_x2[HALF_W-1:0];
        // accumulate
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + {hi3_reg, lo3_reg};
        end
    end

    assign acc  = acc_reg;
    assign busy = v1_reg | v2_reg | v3_reg;

endmodule

`default_nettype wire

// ===== rtl/core/square_matrix_multiply_mod64.sv =====
// Square matrix multiply mod 2^64: stores A and B elements, answers C queries.
// Depends on smm_pkg, smm_mem, smm_mac.
// Write words are taken in the idle state and do not leave it. A C query inside the dim in use
// issues one product per cycle, then raises m_tvalid once the memory read and MAC pipe have
// drained and the output is free, and s_tready returns with it; a query outside skips the products.
// Reset sets dim to 64; matrix storage is not cleared. A held result stalls the next one.
`default_nettype none

module square_matrix_multiply_mod64 #(
    parameter int MAX_DIM = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [smm_pkg::DIM_W-1:0]     cfg_wr_data,   // dim
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [smm_pkg::TDATA_W-1:0]   s_tdata,       // row, col, value
    input  wire logic [smm_pkg::MODE_W-1:0]    s_tuser,       // mode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [smm_pkg::TDATA_W-1:0]   m_tdata        // product, out_row, out_col
);

    import smm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    smm_state_t        state_reg, state_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic              rd_valid_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] prod_reg, prod_next;
    logic [IDX_W-1:0]  orow_reg, orow_next;
    logic [IDX_W-1:0]  ocol_reg, ocol_next;

    logic [IDX_W-1:0]  in_row, in_col;
    logic [DATA_W-1:0] in_value;
    logic              accept, in_store, wr_a, wr_b;
    logic [ADDR_W-1:0] wr_addr;
    logic [DIM_W-1:0]  live_dim;
    logic              in_range;
    logic [DATA_W-1:0] rd_a, rd_b, acc;
    logic              mac_busy, pipe_busy;
    mac_ctl_t          mac_ctl;

    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_store = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_a     = accept && (s_tuser == MODE_WR_A) && in_store;
    assign wr_b     = accept && (s_tuser == MODE_WR_B) && in_store;
    assign wr_addr  = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);

    assign live_dim = (32'(dim_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_reg;
    assign in_range = ({1'b0, in_row} < live_dim) && ({1'b0, in_col} < live_dim);

    assign pipe_busy = rd_valid_reg | mac_busy;

    assign mac_ctl.clear = accept && (s_tuser == MODE_RD_C);
    assign mac_ctl.valid = rd_valid_reg;

    smm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(DATA_W)) u_mem_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (a_addr_reg),
        .rd_data (rd_a)
    );

    smm_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .WIDTH(DATA_W)) u_mem_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (b_addr_reg),
        .rd_data (rd_b)
    );

    smm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (rd_a),
        .op_b    (rd_b),
        .acc     (acc),
        .busy    (mac_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dim_reg      <= DIM_RESET;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_RUN);
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                dim_reg <= cfg_wr_data;
            end
        end
        rem_reg    <= rem_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        prod_reg   <= prod_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
    end

    always_comb begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        m_tvalid_next = m_tvalid_reg;
        prod_next     = prod_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_tuser == MODE_RD_C)) begin
                    row_next    = in_row;
                    col_next    = in_col;
                    rem_next    = live_dim;
                    a_addr_next = ADDR_W'(in_row) * ADDR_W'(MAX_DIM);
                    b_addr_next = ADDR_W'(in_col);
                    state_next  = in_range ? ST_RUN : ST_FIN;
                end
            end
            ST_RUN: begin
                a_addr_next = a_addr_reg + ADDR_W'(1);
                b_addr_next = b_addr_reg + ADDR_W'(MAX_DIM);
                rem_next    = rem_reg - DIM_W'(1);
                if (rem_reg == DIM_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!pipe_busy && (!m_tvalid_reg || m_tready)) begin
                    m_tvalid_next = 1'b1;
                    prod_next     = acc;
                    orow_next     = row_reg;
                    ocol_next     = col_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(TDATA_W-DATA_W-2*IDX_W){1'b0}}, ocol_reg, orow_reg, prod_reg};

    a_rd_follows_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> $past(state_reg == ST_RUN))
        else $error("read data valid without an issue cycle");

    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN) && $past(!pipe_busy))
        else $error("result loaded before the pipeline drained");

    a_accept_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !pipe_busy)
        else $error("word accepted with a product still in flight");

endmodule

`default_nettype wire
